[rtl/msc_pkg.sv]
// Shared types, symbol and request codes, and the Morse code table for the codec.
// No dependencies; used by msc_enc, msc_dec and morse_symbol_codec_core.
package msc_pkg;

    // request kinds
    localparam logic [1:0] KIND_ENC   = 2'd0;
    localparam logic [1:0] KIND_DEC   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // symbol codes
    localparam logic [2:0] SYM_DOT    = 3'd0;
    localparam logic [2:0] SYM_DASH   = 3'd1;
    localparam logic [2:0] SYM_UNIT   = 3'd2;
    localparam logic [2:0] SYM_LETTER = 3'd3;
    localparam logic [2:0] SYM_WORD   = 3'd4;

    localparam int PATTERN_MAX_DEF = 5;
    localparam int CODE_MAX_LEN    = 5;
    localparam int NUM_CODES       = 36;
    localparam int NUM_LETTERS     = 26;

    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [5:0] IDX_E        = 6'd4;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_NULL  = 7'h00;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;

    // element i in bits[i], 1 = dash
    typedef struct packed {
        logic [2:0] len;
        logic [4:0] bits;
    } t_code;

    typedef struct packed {
        logic       valid;
        logic       is_char;
        logic [2:0] sym;
        logic [6:0] ch;
        logic       last;
    } t_res;

    // letters A-Z at 0..25, digits 0-9 at 26..35
    function automatic t_code morse_code(input logic [5:0] idx);
        t_code c;
        unique case (idx)
            6'd0:  c = '{3'd2, 5'b00010};
            6'd1:  c = '{3'd4, 5'b00001};
            6'd2:  c = '{3'd4, 5'b00101};
            6'd3:  c = '{3'd3, 5'b00001};
            6'd4:  c = '{3'd1, 5'b00000};
            6'd5:  c = '{3'd4, 5'b00100};
            6'd6:  c = '{3'd3, 5'b00011};
            6'd7:  c = '{3'd4, 5'b00000};
            6'd8:  c = '{3'd2, 5'b00000};
            6'd9:  c = '{3'd4, 5'b01110};
            6'd10: c = '{3'd3, 5'b00101};
            6'd11: c = '{3'd4, 5'b00010};
            6'd12: c = '{3'd2, 5'b00011};
            6'd13: c = '{3'd2, 5'b00001};
            6'd14: c = '{3'd3, 5'b00111};
            6'd15: c = '{3'd4, 5'b00110};
            6'd16: c = '{3'd4, 5'b01011};
            6'd17: c = '{3'd3, 5'b00010};
            6'd18: c = '{3'd3, 5'b00000};
            6'd19: c = '{3'd1, 5'b00001};
            6'd20: c = '{3'd3, 5'b00100};
            6'd21: c = '{3'd4, 5'b01000};
            6'd22: c = '{3'd3, 5'b00110};
            6'd23: c = '{3'd4, 5'b01001};
            6'd24: c = '{3'd4, 5'b01101};
            6'd25: c = '{3'd4, 5'b00011};
            6'd26: c = '{3'd5, 5'b11111};
            6'd27: c = '{3'd5, 5'b11110};
            6'd28: c = '{3'd5, 5'b11100};
            6'd29: c = '{3'd5, 5'b11000};
            6'd30: c = '{3'd5, 5'b10000};
            6'd31: c = '{3'd5, 5'b00000};
            6'd32: c = '{3'd5, 5'b00001};
            6'd33: c = '{3'd5, 5'b00011};
            6'd34: c = '{3'd5, 5'b00111};
            6'd35: c = '{3'd5, 5'b01111};
            default: c = '{3'd1, 5'b00000};
        endcase
        return c;
    endfunction

    // character for a collected pattern, CHAR_NULL when nothing matches
    function automatic logic [6:0] morse_lookup(input logic [2:0] len, input logic [4:0] bits);
        logic [6:0] ch;
        t_code      c;
        ch = CHAR_NULL;
        for (int i = 0; i < NUM_CODES; i++) begin
            c = morse_code(6'(i));
            if (c.len == len && c.bits == bits) begin
                if (i < NUM_LETTERS) begin
                    ch = CHAR_A + 7'(i);
                end else begin
                    ch = CHAR_ZERO + 7'(i - NUM_LETTERS);
                end
            end
        end
        return ch;
    endfunction

endpackage

[rtl/morse_symbol_codec_core.sv]
// Morse symbol codec. An accepted request's first result is held in the encoder or
// decoder state registers, then in the output register; one result per cycle follows
// while the output is not stalled. Encode emits 1 to 10 results; a dot, dash, unit
// gap, letter gap or out-of-range code with no pattern, or ignored kind emits none;
// the encoder shift register and decoder emit sequencer stall the input.
// Synchronous active-low reset clears the pattern, the encoder history and output valid.
module morse_symbol_codec_core #(
    parameter int PATTERN_MAX = msc_pkg::PATTERN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_in,
    input  logic [2:0] i_symbol_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_out_is_char,
    output logic [2:0] o_symbol_out,
    output logic [6:0] o_char_out,
    output logic       o_last
);

    logic          accept;
    logic          take;
    logic          enc_busy;
    logic          dec_busy;
    msc_pkg::t_res enc_res;
    msc_pkg::t_res dec_res;
    msc_pkg::t_res sel_res;

    logic       r_out_valid;
    logic       r_is_char;
    logic [2:0] r_sym;
    logic [6:0] r_ch;
    logic       r_last;

    assign o_in_stall = enc_busy || dec_busy;
    assign accept     = i_in_valid && !o_in_stall;
    // output register free or emptying this cycle
    assign take       = !r_out_valid || !i_out_stall;

    msc_enc u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && i_kind == msc_pkg::KIND_ENC),
        .i_char  (i_char_in),
        .i_take  (take),
        .o_busy  (enc_busy),
        .o_res   (enc_res)
    );

    msc_dec #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_kind == msc_pkg::KIND_DEC || i_kind == msc_pkg::KIND_FLUSH)),
        .i_flush (i_kind == msc_pkg::KIND_FLUSH),
        .i_sym   (i_symbol_in),
        .i_take  (take),
        .o_busy  (dec_busy),
        .o_res   (dec_res)
    );

    assign sel_res = enc_res.valid ? enc_res : dec_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= sel_res.valid;
        end
        if (take) begin
            r_is_char <= sel_res.is_char;
            r_sym     <= sel_res.sym;
            r_ch      <= sel_res.ch;
            r_last    <= sel_res.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_is_char = r_is_char;
    assign o_symbol_out  = r_sym;
    assign o_char_out    = r_ch;
    assign o_last        = r_last;

endmodule

[rtl/msc_enc.sv]
// Encode path: shifts out a character's Morse elements, unit gaps in between.
// Depends on msc_pkg for the code table, symbol codes and result type.
module msc_enc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [7:0]       i_char,
    input  logic             i_take,
    output logic             o_busy,
    output msc_pkg::t_res    o_res
);

    logic       r_active, n_active;
    logic       r_word, n_word;
    logic       r_lead, n_lead;
    logic       r_unit, n_unit;
    logic       r_last_elem, n_last_elem;
    logic [4:0] r_bits, n_bits;
    logic [2:0] r_cnt, n_cnt;

    logic [7:0]     upper;
    logic [5:0]     idx;
    msc_pkg::t_code code;

    always_comb begin
        upper = i_char;
        if (i_char >= msc_pkg::ASCII_LOWER_A && i_char <= msc_pkg::ASCII_LOWER_Z) begin
            upper = i_char - msc_pkg::CASE_OFFSET;
        end
        priority if (upper >= msc_pkg::ASCII_UPPER_A && upper <= msc_pkg::ASCII_UPPER_Z) begin
            idx = 6'(upper - msc_pkg::ASCII_UPPER_A);
        end else if (upper >= msc_pkg::ASCII_ZERO && upper <= msc_pkg::ASCII_NINE) begin
            idx = 6'(upper - msc_pkg::ASCII_ZERO) + 6'(msc_pkg::NUM_LETTERS);
        end else begin
            idx = msc_pkg::IDX_E;
        end
        code = msc_pkg::morse_code(idx);
    end

    always_comb begin
        o_res.valid   = r_active;
        o_res.is_char = 1'b0;
        o_res.ch      = msc_pkg::CHAR_NULL;
        priority if (r_word) begin
            o_res.sym = msc_pkg::SYM_WORD;
        end else if (r_lead) begin
            o_res.sym = msc_pkg::SYM_LETTER;
        end else if (r_unit) begin
            o_res.sym = msc_pkg::SYM_UNIT;
        end else begin
            o_res.sym = r_bits[0] ? msc_pkg::SYM_DASH : msc_pkg::SYM_DOT;
        end
        o_res.last = r_word || (!r_lead && !r_unit && r_cnt == 3'd1);
    end

    assign o_busy = r_active;

    always_comb begin
        n_active    = r_active;
        n_word      = r_word;
        n_lead      = r_lead;
        n_unit      = r_unit;
        n_last_elem = r_last_elem;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        if (i_start) begin
            n_active = 1'b1;
            n_unit   = 1'b0;
            if (upper == msc_pkg::ASCII_SPACE) begin
                n_word      = 1'b1;
                n_lead      = 1'b0;
                n_last_elem = 1'b0;
            end else begin
                n_word      = 1'b0;
                n_lead      = r_last_elem;
                n_last_elem = 1'b1;
                n_bits      = code.bits;
                n_cnt       = code.len;
            end
        end else if (r_active && i_take) begin
            priority if (r_word) begin
                n_word   = 1'b0;
                n_active = 1'b0;
            end else if (r_lead) begin
                n_lead = 1'b0;
            end else if (r_unit) begin
                n_unit = 1'b0;
            end else begin
                // advance to the next element, a unit gap goes first
                n_bits = {1'b0, r_bits[4:1]};
                n_cnt  = r_cnt - 3'd1;
                n_unit = 1'b1;
                if (r_cnt == 3'd1) begin
                    n_active = 1'b0;
                    n_unit   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_word      <= 1'b0;
            r_lead      <= 1'b0;
            r_unit      <= 1'b0;
            r_last_elem <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_word      <= n_word;
            r_lead      <= n_lead;
            r_unit      <= n_unit;
            r_last_elem <= n_last_elem;
        end
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
    end

endmodule

[rtl/msc_dec.sv]
// Decode path: collects elements one per request into a pattern register and
// emits the pending character and gap/terminator characters. Depends on msc_pkg.
module msc_dec #(
    parameter int PATTERN_MAX = msc_pkg::PATTERN_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_flush,
    input  logic [2:0]       i_sym,
    input  logic             i_take,
    output logic             o_busy,
    output msc_pkg::t_res    o_res
);

    localparam int LW = $clog2(PATTERN_MAX + 2);
    localparam int IW = $clog2(PATTERN_MAX);

    logic [PATTERN_MAX-1:0] r_bits, n_bits;
    logic [LW-1:0]          r_len, n_len;
    logic                   r_pend, n_pend;
    logic                   r_tail, n_tail;
    logic [6:0]             r_tail_ch, n_tail_ch;

    logic       has_pattern;
    logic [6:0] pat_ch;

    assign has_pattern = (r_len != '0);

    always_comb begin
        if (has_pattern && r_len <= LW'(msc_pkg::CODE_MAX_LEN)) begin
            pat_ch = msc_pkg::morse_lookup(r_len[2:0], r_bits[4:0]);
        end else begin
            pat_ch = msc_pkg::CHAR_NULL;
        end
    end

    assign o_busy = r_pend || r_tail;

    always_comb begin
        o_res.valid   = r_pend || r_tail;
        o_res.is_char = 1'b1;
        o_res.sym     = msc_pkg::SYM_DOT;
        o_res.ch      = r_pend ? pat_ch : r_tail_ch;
        o_res.last    = r_pend ? !r_tail : 1'b1;
    end

    always_comb begin
        n_bits    = r_bits;
        n_len     = r_len;
        n_pend    = r_pend;
        n_tail    = r_tail;
        n_tail_ch = r_tail_ch;
        if (i_start) begin
            if (i_flush) begin
                n_pend    = has_pattern;
                n_tail    = 1'b1;
                n_tail_ch = msc_pkg::CHAR_NULL;
            end else begin
                unique case (i_sym)
                    msc_pkg::SYM_DOT, msc_pkg::SYM_DASH: begin
                        if (r_len < LW'(PATTERN_MAX)) begin
                            if (i_sym == msc_pkg::SYM_DASH) begin
                                n_bits[r_len[IW-1:0]] = 1'b1;
                            end
                            n_len = r_len + LW'(1);
                        end else begin
                            // saturate: over-long pattern
                            n_len = LW'(PATTERN_MAX + 1);
                        end
                    end
                    msc_pkg::SYM_UNIT: begin
                    end
                    msc_pkg::SYM_WORD: begin
                        n_pend    = has_pattern;
                        n_tail    = 1'b1;
                        n_tail_ch = msc_pkg::CHAR_SPACE;
                    end
                    default: begin
                        n_pend = has_pattern;
                    end
                endcase
            end
        end else if (i_take && o_busy) begin
            priority if (r_pend) begin
                n_pend = 1'b0;
                n_bits = '0;
                n_len  = '0;
            end else begin
                n_tail = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_len  <= '0;
            r_pend <= 1'b0;
            r_tail <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_len  <= n_len;
            r_pend <= n_pend;
            r_tail <= n_tail;
        end
        r_tail_ch <= n_tail_ch;
    end

endmodule

[bench/morse_symbol_codec_checker.sv]
`timescale 1ns / 1ps
// Result checker for morse_symbol_codec_core: mirrors the encoder history and the
// decoder pattern, and compares every delivered result with the oldest one due.
// Depends on msc_pkg for request kinds, symbol codes and ASCII constants.
module morse_symbol_codec_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_in,
    input  logic [2:0] i_symbol_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_out_is_char,
    input  logic [2:0] i_symbol_out,
    input  logic [6:0] i_char_out,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int         PAT_MAX = msc_pkg::PATTERN_MAX_DEF;
    // symbol field of a character result
    localparam logic [2:0] NO_SYM  = 3'd0;

    typedef struct packed {
        logic       is_char;
        logic [2:0] sym;
        logic [6:0] ch;
        logic       last;
    } t_codec_result;

    t_codec_result codec_results_due[$];

    logic       enc_after_element = 1'b0;
    logic [4:0] pat_bits = '0;
    logic [2:0] pat_len = '0;
    int         fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic string morse_pattern(input int idx);
        string p;
        case (idx)
            0: p = ".-";     1: p = "-...";   2: p = "-.-.";   3: p = "-..";
            4: p = ".";      5: p = "..-.";   6: p = "--.";    7: p = "....";
            8: p = "..";     9: p = ".---";   10: p = "-.-";   11: p = ".-..";
            12: p = "--";    13: p = "-.";    14: p = "---";   15: p = ".--.";
            16: p = "--.-";  17: p = ".-.";   18: p = "...";   19: p = "-";
            20: p = "..-";   21: p = "...-";  22: p = ".--";   23: p = "-..-";
            24: p = "-.--";  25: p = "--..";
            26: p = "-----"; 27: p = ".----"; 28: p = "..---"; 29: p = "...--";
            30: p = "....-"; 31: p = "....."; 32: p = "-...."; 33: p = "--...";
            34: p = "---.."; default: p = "----.";
        endcase
        return p;
    endfunction

    function automatic void push_result(input logic is_char, input logic [2:0] sym,
                                        input logic [6:0] ch);
        t_codec_result r;
        r.is_char = is_char;
        r.sym     = sym;
        r.ch      = ch;
        r.last    = 1'b0;
        codec_results_due.push_back(r);
    endfunction

    // character for the collected pattern, null when unknown or over-long
    function automatic logic [6:0] pattern_char();
        string      p;
        logic [4:0] b;
        logic [6:0] ch;
        ch = msc_pkg::CHAR_NULL;
        if (pat_len != 0 && pat_len <= PAT_MAX) begin
            for (int i = 0; i < msc_pkg::NUM_CODES; i++) begin
                p = morse_pattern(i);
                b = '0;
                for (int j = 0; j < p.len(); j++) begin
                    if (p[j] == "-") b[j] = 1'b1;
                end
                if (p.len() == pat_len && b == pat_bits) begin
                    if (i < msc_pkg::NUM_LETTERS) begin
                        ch = msc_pkg::CHAR_A + 7'(i);
                    end else begin
                        ch = msc_pkg::CHAR_ZERO + 7'(i - msc_pkg::NUM_LETTERS);
                    end
                end
            end
        end
        return ch;
    endfunction

    function automatic void emit_pending_char();
        if (pat_len != 0) begin
            push_result(1'b1, NO_SYM, pattern_char());
            pat_bits = '0;
            pat_len  = '0;
        end
    endfunction

    function automatic void encode_char(input logic [7:0] c);
        string p;
        int    idx;
        if (c >= msc_pkg::ASCII_LOWER_A && c <= msc_pkg::ASCII_LOWER_Z) begin
            c = c - msc_pkg::CASE_OFFSET;
        end
        if (c == msc_pkg::ASCII_SPACE) begin
            enc_after_element = 1'b0;
            push_result(1'b0, msc_pkg::SYM_WORD, msc_pkg::CHAR_NULL);
        end else begin
            if (c >= msc_pkg::ASCII_UPPER_A && c <= msc_pkg::ASCII_UPPER_Z) begin
                idx = int'(c - msc_pkg::ASCII_UPPER_A);
            end else if (c >= msc_pkg::ASCII_ZERO && c <= msc_pkg::ASCII_NINE) begin
                idx = msc_pkg::NUM_LETTERS + int'(c - msc_pkg::ASCII_ZERO);
            end else begin
                idx = int'(msc_pkg::IDX_E);
            end
            if (enc_after_element) begin
                push_result(1'b0, msc_pkg::SYM_LETTER, msc_pkg::CHAR_NULL);
            end
            p = morse_pattern(idx);
            for (int j = 0; j < p.len(); j++) begin
                if (j != 0) push_result(1'b0, msc_pkg::SYM_UNIT, msc_pkg::CHAR_NULL);
                push_result(1'b0, (p[j] == "-") ? msc_pkg::SYM_DASH : msc_pkg::SYM_DOT,
                            msc_pkg::CHAR_NULL);
            end
            enc_after_element = 1'b1;
        end
    endfunction

    function automatic void decode_symbol(input logic [2:0] s);
        if (s == msc_pkg::SYM_DOT || s == msc_pkg::SYM_DASH) begin
            if (pat_len < PAT_MAX) begin
                if (s == msc_pkg::SYM_DASH) pat_bits[pat_len] = 1'b1;
                pat_len = pat_len + 3'd1;
            end else begin
                // saturate: an over-long pattern decodes as null
                pat_len = 3'(PAT_MAX + 1);
            end
        end else if (s != msc_pkg::SYM_UNIT) begin
            // letter gap, word gap and codes above word gap all close the letter
            emit_pending_char();
            if (s == msc_pkg::SYM_WORD) push_result(1'b1, NO_SYM, msc_pkg::CHAR_SPACE);
        end
    endfunction

    function automatic void step_codec(input logic [1:0] kind, input logic [7:0] c,
                                       input logic [2:0] s);
        int            before_cnt;
        t_codec_result r;
        before_cnt = codec_results_due.size();
        case (kind)
            msc_pkg::KIND_ENC:   encode_char(c);
            msc_pkg::KIND_DEC:   decode_symbol(s);
            msc_pkg::KIND_FLUSH: begin
                emit_pending_char();
                push_result(1'b1, NO_SYM, msc_pkg::CHAR_NULL);
            end
            default: ;
        endcase
        if (codec_results_due.size() > before_cnt) begin
            r = codec_results_due.pop_back();
            r.last = 1'b1;
            codec_results_due.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_codec_result got;
        t_codec_result want;
        if (!i_rst_n) begin
            enc_after_element = 1'b0;
            pat_bits = '0;
            pat_len  = '0;
            codec_results_due.delete();
        end else begin
            // compare first so a stray result is not matched against this edge's request
            if (i_out_valid && !i_out_stall) begin
                got.is_char = i_out_is_char;
                got.sym     = i_symbol_out;
                got.ch      = i_char_out;
                got.last    = i_last;
                if (codec_results_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("%0t: unexpected result is_char=%0d sym=%0d ch=%02h last=%0d",
                                 $time, got.is_char, got.sym, got.ch, got.last);
                    end
                end else begin
                    want = codec_results_due.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t: result differs: expected is_char=%0d sym=%0d %s",
                                     $time, want.is_char, want.sym,
                                     $sformatf("ch=%02h last=%0d", want.ch, want.last));
                            $display("%0t:                 got is_char=%0d sym=%0d %s",
                                     $time, got.is_char, got.sym,
                                     $sformatf("ch=%02h last=%0d", got.ch, got.last));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) step_codec(i_kind, i_char_in, i_symbol_in);
        end
        o_pending <= codec_results_due.size();
    end

endmodule

[bench/morse_symbol_codec_core_tb.sv]
`timescale 1ns / 1ps
// Top of the Morse codec bench: clock, reset, request stimulus and output stalls,
// with the verdict. Depends on msc_pkg, morse_symbol_codec_core and the checker.
module morse_symbol_codec_core_tb;

    localparam int         ITEM_TARGET    = 230;
    localparam int         QUIET_TAIL     = 40;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 20;
    // request kind the block accepts and ignores
    localparam logic [1:0] KIND_IGNORED   = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = msc_pkg::KIND_ENC;
    logic [7:0] char_in = '0;
    logic [2:0] symbol_in = msc_pkg::SYM_DOT;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       out_is_char;
    logic [2:0] symbol_out;
    logic [6:0] char_out;
    logic       last;

    int fail_count;
    int pending;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int enc_cnt = 0;
    int dec_cnt = 0;
    int flush_cnt = 0;
    int ignored_cnt = 0;

    always #5 clk = ~clk;

    morse_symbol_codec_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_char_in     (char_in),
        .i_symbol_in   (symbol_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_is_char (out_is_char),
        .o_symbol_out  (symbol_out),
        .o_char_out    (char_out),
        .o_last        (last)
    );

    morse_symbol_codec_checker morse_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (kind),
        .i_char_in     (char_in),
        .i_symbol_in   (symbol_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_is_char (out_is_char),
        .i_symbol_out  (symbol_out),
        .i_char_out    (char_out),
        .i_last        (last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // output stalls start at random and then run on as a burst
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) results_seen <= results_seen + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // drive one request and hold it until accepted; returns in the accepting step
    task automatic send_req(input logic [1:0] k, input logic [7:0] c, input logic [2:0] s);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        char_in   <= c;
        symbol_in <= s;
        do @(posedge clk); while (in_stall);
        case (k)
            msc_pkg::KIND_ENC:   enc_cnt++;
            msc_pkg::KIND_DEC:   dec_cnt++;
            msc_pkg::KIND_FLUSH: flush_cnt++;
            default:             ignored_cnt++;
        endcase
        if (k != KIND_IGNORED) requests_sent++;
    endtask

    task automatic enc(input logic [7:0] c);
        send_req(msc_pkg::KIND_ENC, c, 3'($urandom_range(0, 7)));
    endtask

    task automatic dec(input logic [2:0] s);
        send_req(msc_pkg::KIND_DEC, 8'($urandom_range(0, 255)), s);
    endtask

    task automatic flush();
        send_req(msc_pkg::KIND_FLUSH, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endtask

    // a pattern's elements, unit gaps between if units; element i dash if bits[i]
    task automatic send_elements(input int len, input logic [8:0] bits, input bit units);
        for (int i = 0; i < len; i++) begin
            if (i != 0 && units) dec(msc_pkg::SYM_UNIT);
            dec(bits[i] ? msc_pkg::SYM_DASH : msc_pkg::SYM_DOT);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int          r;
        int          len;
        int          d;
        logic [8:0]  bits;
        bit          drained_mid;
        drained_mid = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 25;
        stall_pct = 25;

        // directed: case folding, digits, space, non-alphanumeric, ignored kind
        enc(msc_pkg::ASCII_UPPER_A);
        enc(msc_pkg::ASCII_LOWER_Z);
        enc(msc_pkg::ASCII_NINE);
        enc(msc_pkg::ASCII_SPACE);
        enc(8'hFF);
        enc(8'h00);
        send_req(KIND_IGNORED, 8'hFF, 3'd7);
        // K with a unit gap after its first element only, closed by a letter gap
        dec(msc_pkg::SYM_DASH); dec(msc_pkg::SYM_UNIT); dec(msc_pkg::SYM_DOT);
        dec(msc_pkg::SYM_DASH); dec(msc_pkg::SYM_LETTER);
        flush();
        // unknown pattern closed by a word gap
        send_elements(4, 9'b000001100, 1'b0);
        dec(msc_pkg::SYM_WORD);
        // over-long pattern closed by an out-of-range code
        send_elements(6, 9'b000000000, 1'b0);
        dec(3'd7);
        dec(msc_pkg::SYM_DOT);
        flush();
        dec(msc_pkg::SYM_WORD);
        hold_until_drained();

        while (requests_sent < ITEM_TARGET) begin
            if (requests_sent >= ITEM_TARGET - QUIET_TAIL || (requests_sent / 30) % 2 == 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 30;
                stall_pct = 30;
            end
            if (!drained_mid && requests_sent >= ITEM_TARGET / 2) begin
                drained_mid = 1'b1;
                hold_until_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                d = $urandom_range(0, 99);
                if (d < 30)      enc(msc_pkg::ASCII_UPPER_A + 8'($urandom_range(0, 25)));
                else if (d < 55) enc(msc_pkg::ASCII_LOWER_A + 8'($urandom_range(0, 25)));
                else if (d < 70) enc(msc_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
                else if (d < 80) enc(msc_pkg::ASCII_SPACE);
                else             enc(8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                if (r < 80) begin
                    if ($urandom_range(0, 3) == 0) begin
                        // digit shape: leading dots then dashes, or dashes then dots
                        d = $urandom_range(0, 9);
                        len = 5;
                        bits = '0;
                        for (int i = 0; i < 5; i++) bits[i] = (d <= 5) ? (i >= d) : (i < d - 5);
                    end else begin
                        len = $urandom_range(1, 4);
                        bits = 9'($urandom_range(0, 511));
                    end
                end else begin
                    len = $urandom_range(5, 9);
                    bits = 9'($urandom_range(0, 511));
                end
                send_elements(len, bits, $urandom_range(0, 3) != 0);
                d = $urandom_range(0, 99);
                if (d < 60)      dec(msc_pkg::SYM_LETTER);
                else if (d < 80) dec(msc_pkg::SYM_WORD);
                else if (d < 88) flush();
                else             dec(3'($urandom_range(5, 7)));
            end else if (r < 95) begin
                flush();
            end else begin
                // noise: ignored kind or a stray gap code
                if ($urandom_range(0, 1) == 0) begin
                    send_req(KIND_IGNORED, 8'($urandom_range(0, 255)),
                             3'($urandom_range(0, 7)));
                end else begin
                    dec(3'($urandom_range(2, 7)));
                end
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d encode, %0d decode, %0d flush, %0d ignored",
                 requests_sent + ignored_cnt, enc_cnt, dec_cnt, flush_cnt, ignored_cnt);
        $display("Checked %0d results over letters, digits, gaps, unknown and long patterns",
                 results_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/msc_pkg.sv
rtl/msc_enc.sv
rtl/msc_dec.sv
rtl/morse_symbol_codec_core.sv
bench/morse_symbol_codec_checker.sv
bench/morse_symbol_codec_core_tb.sv
